// ===== sv/dpw_pkg.sv =====
// Shared types, widths, register map and reset values for the depth pixel to world point unit.
package dpw_pkg;

  localparam int ROT_FRAC  = 13;
  localparam int CAM_FRAC  = 8;
  localparam int FOC_FRAC  = 24;
  localparam int XC_SHIFT  = FOC_FRAC - CAM_FRAC;
  localparam int W_SHIFT   = ROT_FRAC + CAM_FRAC;

  localparam int COORD_W   = 12;
  localparam int DEPTH_W   = 16;
  localparam int FOC_W     = 24;
  localparam int OUT_W     = 24;

  localparam int DX_W      = COORD_W + 1;
  localparam int PP_W      = DX_W + DEPTH_W + 1;
  localparam int MX_W      = PP_W + FOC_W + 1;
  localparam int XC_W      = 37;
  localparam int XLO_W     = 16;
  localparam int XHI_W     = XC_W - XLO_W;
  localparam int ROT_W     = 16;
  localparam int ACC_W     = 56;
  localparam int Q_W       = ACC_W - W_SHIFT;

  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam logic [2:0] REG_MIN_DEPTH = 3'd0;
  localparam logic [2:0] REG_MAX_DEPTH = 3'd1;
  localparam logic [2:0] REG_INV_FOCAL = 3'd2;
  localparam logic [2:0] REG_PRINC_X   = 3'd3;
  localparam logic [2:0] REG_PRINC_Y   = 3'd4;
  localparam logic [2:0] REG_POSE_X    = 3'd5;
  localparam logic [2:0] REG_POSE_Y    = 3'd6;
  localparam logic [2:0] REG_POSE_Z    = 3'd7;

  localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 16'd100;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'd10000;
  localparam logic [FOC_W-1:0]   INV_FOCAL_RST = 24'd28679;
  localparam logic [COORD_W-1:0] PRINC_X_RST   = 12'd320;
  localparam logic [COORD_W-1:0] PRINC_Y_RST   = 12'd240;
  localparam logic [63:0]        POSE_X_RST    = 64'd1 << ROT_FRAC;
  localparam logic [63:0]        POSE_Y_RST    = 64'd1 << (ROT_FRAC + 16);
  localparam logic [63:0]        POSE_Z_RST    = 64'd1 << (ROT_FRAC + 32);

  typedef struct packed {
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
    logic [DEPTH_W-1:0] depth_mm;
  } pixel_t;

  typedef struct packed {
    logic                    point_valid;
    logic signed [OUT_W-1:0] world_x_mm;
    logic signed [OUT_W-1:0] world_y_mm;
    logic signed [OUT_W-1:0] world_z_mm;
  } point_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] min_depth_mm;
    logic [DEPTH_W-1:0] max_depth_mm;
    logic [FOC_W-1:0]   inverse_focal;
    logic [COORD_W-1:0] principal_x;
    logic [COORD_W-1:0] principal_y;
    logic [63:0]        pose_row_x;
    logic [63:0]        pose_row_y;
    logic [63:0]        pose_row_z;
  } cfg_t;

  typedef struct packed {
    logic                   ok;
    logic [DEPTH_W-1:0]     d;
    logic signed [XC_W-1:0] xc;
    logic signed [XC_W-1:0] yc;
  } cam_t;

  typedef struct packed {
    logic s5;
    logic s6;
    logic s7;
  } axis_en_t;

endpackage

// ===== sv/depth_pixel_to_world_point_unit.sv =====
// Top level: configuration registers, camera stage, three pose rows and output handshake.
// Takes one depth pixel per clock when the output is not stalled and returns one world point
// for each, in order, on the output.
// The seven register stages are
// offset and range check, two multiplier stages (offset times depth, then times the
// reciprocal focal length), camera rounding, rotation partial products, accumulation and
// saturation into the output register. Each stage has its own valid bit and moves when the
// stage after it is free, so empty slots close up under a stall and new pixels keep being
// taken until the pipeline is full. Write the registers only while the unit is empty.
module depth_pixel_to_world_point_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  dpw_pkg::pixel_t             pix,
  output logic                        pt_valid,
  input  logic                        pt_stall,
  output dpw_pkg::point_t             pt,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpw_pkg::ADDR_W-1:0]  paddr,
  input  logic [dpw_pkg::DATA_W-1:0]  pwdata,
  output logic [dpw_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import dpw_pkg::*;

  cfg_t     cfg;
  cam_t     cam;
  axis_en_t en;
  logic     cam_valid, cam_ready, pix_ready;
  logic     v5, v6, v7;
  logic     rdy5, rdy6, rdy7;
  logic     s5_ok, s6_ok;
  logic     pt_ok;
  logic signed [OUT_W-1:0] wx, wy, wz;
  logic     wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_depth_mm  <= MIN_DEPTH_RST;
      cfg.max_depth_mm  <= MAX_DEPTH_RST;
      cfg.inverse_focal <= INV_FOCAL_RST;
      cfg.principal_x   <= PRINC_X_RST;
      cfg.principal_y   <= PRINC_Y_RST;
      cfg.pose_row_x    <= POSE_X_RST;
      cfg.pose_row_y    <= POSE_Y_RST;
      cfg.pose_row_z    <= POSE_Z_RST;
    end else if (wr) begin
      case (reg_idx)
        REG_MIN_DEPTH: cfg.min_depth_mm  <= pwdata[DEPTH_W-1:0];
        REG_MAX_DEPTH: cfg.max_depth_mm  <= pwdata[DEPTH_W-1:0];
        REG_INV_FOCAL: cfg.inverse_focal <= pwdata[FOC_W-1:0];
        REG_PRINC_X:   cfg.principal_x   <= pwdata[COORD_W-1:0];
        REG_PRINC_Y:   cfg.principal_y   <= pwdata[COORD_W-1:0];
        REG_POSE_X:    cfg.pose_row_x    <= pwdata;
        REG_POSE_Y:    cfg.pose_row_y    <= pwdata;
        REG_POSE_Z:    cfg.pose_row_z    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_DEPTH: prdata = DATA_W'(cfg.min_depth_mm);
      REG_MAX_DEPTH: prdata = DATA_W'(cfg.max_depth_mm);
      REG_INV_FOCAL: prdata = DATA_W'(cfg.inverse_focal);
      REG_PRINC_X:   prdata = DATA_W'(cfg.principal_x);
      REG_PRINC_Y:   prdata = DATA_W'(cfg.principal_y);
      REG_POSE_X:    prdata = cfg.pose_row_x;
      REG_POSE_Y:    prdata = cfg.pose_row_y;
      REG_POSE_Z:    prdata = cfg.pose_row_z;
      default:       prdata = '0;
    endcase
  end

  dpw_cam u_cam (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .cfg       (cfg),
    .cam_valid (cam_valid),
    .cam_ready (cam_ready),
    .cam       (cam)
  );

  assign pix_stall = !pix_ready;

  assign rdy7      = !v7 || !pt_stall;
  assign rdy6      = !v6 || rdy7;
  assign rdy5      = !v5 || rdy6;
  assign cam_ready = rdy5;
  assign en        = '{s5: rdy5, s6: rdy6, s7: rdy7};
  assign pt_valid  = v7;
  assign pt        = '{point_valid: pt_ok, world_x_mm: wx, world_y_mm: wy, world_z_mm: wz};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy5) v5 <= cam_valid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) s5_ok <= cam.ok;
    if (rdy6) s6_ok <= s5_ok;
    if (rdy7) pt_ok <= s6_ok;
  end

  dpw_axis u_axis_x (
    .clk   (clk),
    .en    (en),
    .cam   (cam),
    .row   (cfg.pose_row_x),
    .coord (wx)
  );

  dpw_axis u_axis_y (
    .clk   (clk),
    .en    (en),
    .cam   (cam),
    .row   (cfg.pose_row_y),
    .coord (wy)
  );

  dpw_axis u_axis_z (
    .clk   (clk),
    .en    (en),
    .cam   (cam),
    .row   (cfg.pose_row_z),
    .coord (wz)
  );

endmodule

// ===== sv/dpw_cam.sv =====
// Four-stage back-projection of a depth pixel to a camera-space point.
module dpw_cam (
  input  logic           clk,
  input  logic           rst,
  input  logic           pix_valid,
  output logic           pix_ready,
  input  dpw_pkg::pixel_t pix,
  input  dpw_pkg::cfg_t  cfg,
  output logic           cam_valid,
  input  logic           cam_ready,
  output dpw_pkg::cam_t  cam
);
  import dpw_pkg::*;

  localparam logic signed [MX_W-1:0] XC_HALF = MX_W'(1) <<< (XC_SHIFT - 1);

  logic [4:1] v;
  logic [4:1] rdy;

  logic signed [DX_W-1:0] s1_dx, s1_dy;
  logic [DEPTH_W-1:0]     s1_d;
  logic                   s1_ok;

  logic signed [PP_W-1:0] s2_px, s2_py;
  logic [DEPTH_W-1:0]     s2_d;
  logic                   s2_ok;

  logic signed [MX_W-1:0] s3_mx, s3_my;
  logic [DEPTH_W-1:0]     s3_d;
  logic                   s3_ok;

  logic signed [MX_W-1:0] sum_x, sum_y;
  logic signed [DEPTH_W:0] d_s;
  logic signed [FOC_W:0]   f_s;

  assign rdy[4] = !v[4] || cam_ready;
  assign rdy[3] = !v[3] || rdy[4];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign pix_ready = rdy[1];
  assign cam_valid = v[4];

  assign d_s   = $signed({1'b0, s1_d});
  assign f_s   = $signed({1'b0, cfg.inverse_focal});
  assign sum_x = s3_mx + XC_HALF;
  assign sum_y = s3_my + XC_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= pix_valid;
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_dx <= $signed({1'b0, pix.pixel_column}) - $signed({1'b0, cfg.principal_x});
      s1_dy <= $signed({1'b0, pix.pixel_row}) - $signed({1'b0, cfg.principal_y});
      s1_d  <= pix.depth_mm;
      s1_ok <= (pix.depth_mm >= cfg.min_depth_mm) && (pix.depth_mm <= cfg.max_depth_mm);
    end
    if (rdy[2]) begin
      s2_px <= s1_dx * d_s;
      s2_py <= s1_dy * d_s;
      s2_d  <= s1_d;
      s2_ok <= s1_ok;
    end
    if (rdy[3]) begin
      s3_mx <= s2_px * f_s;
      s3_my <= s2_py * f_s;
      s3_d  <= s2_d;
      s3_ok <= s2_ok;
    end
    if (rdy[4]) begin
      cam.ok <= s3_ok;
      cam.d  <= s3_d;
      cam.xc <= sum_x[XC_SHIFT +: XC_W];
      cam.yc <= sum_y[XC_SHIFT +: XC_W];
    end
  end

endmodule

// ===== sv/dpw_axis.sv =====
// Three-stage pose row: rotation plus translation for one world axis, rounding and saturation.
module dpw_axis (
  input  logic                          clk,
  input  dpw_pkg::axis_en_t             en,
  input  dpw_pkg::cam_t                 cam,
  input  logic [63:0]                   row,
  output logic signed [dpw_pkg::OUT_W-1:0] coord
);
  import dpw_pkg::*;

  localparam logic signed [ACC_W-1:0] W_HALF = ACC_W'(1) <<< (W_SHIFT - 1);

  logic signed [ROT_W-1:0] r0, r1, r2, tr;
  logic signed [XLO_W:0]   xlo, ylo;
  logic signed [XHI_W-1:0] xhi, yhi;
  logic signed [DEPTH_W:0] d_s;

  logic signed [ROT_W+XLO_W:0]   s5_p0l, s5_p1l;
  logic signed [ROT_W+XHI_W-1:0] s5_p0h, s5_p1h;
  logic signed [ROT_W+DEPTH_W:0] s5_p2;
  logic signed [ROT_W-1:0]       s5_t;
  logic                          s5_ok;

  logic signed [ACC_W-1:0] s6_acc;
  logic                    s6_ok;

  logic signed [ACC_W-1:0] acc_next;
  logic signed [Q_W-1:0]   q;
  logic [Q_W-OUT_W:0]      q_hi;
  logic signed [OUT_W-1:0] sat;

  assign r0  = $signed(row[15:0]);
  assign r1  = $signed(row[31:16]);
  assign r2  = $signed(row[47:32]);
  assign tr  = $signed(row[63:48]);
  assign xlo = $signed({1'b0, cam.xc[XLO_W-1:0]});
  assign ylo = $signed({1'b0, cam.yc[XLO_W-1:0]});
  assign xhi = cam.xc[XC_W-1:XLO_W];
  assign yhi = cam.yc[XC_W-1:XLO_W];
  assign d_s = $signed({1'b0, cam.d});

  assign acc_next = (ACC_W'(s5_p0h) <<< XLO_W) + ACC_W'(s5_p0l)
                  + (ACC_W'(s5_p1h) <<< XLO_W) + ACC_W'(s5_p1l)
                  + (ACC_W'(s5_p2) <<< CAM_FRAC) + (ACC_W'(s5_t) <<< W_SHIFT) + W_HALF;

  assign q    = s6_acc[ACC_W-1:W_SHIFT];
  assign q_hi = q[Q_W-1:OUT_W-1];

  always_comb begin
    if (&q_hi || ~|q_hi) begin
      sat = q[OUT_W-1:0];
    end else begin
      sat = {q[Q_W-1], {(OUT_W-1){~q[Q_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      s5_p0l <= r0 * xlo;
      s5_p0h <= r0 * xhi;
      s5_p1l <= r1 * ylo;
      s5_p1h <= r1 * yhi;
      s5_p2  <= r2 * d_s;
      s5_t   <= tr;
      s5_ok  <= cam.ok;
    end
    if (en.s6) begin
      s6_acc <= acc_next;
      s6_ok  <= s5_ok;
    end
    if (en.s7) begin
      coord <= s6_ok ? sat : '0;
    end
  end

endmodule
